// File: rtl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Holds the request kinds, the controller states and the result record.
// No dependencies.
`default_nettype none

package tccw_pkg;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;
  localparam logic [7:0] ATTR_RESET   = 8'h07;

  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_SET   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCROLL,
    S_BLANK,
    S_PUT,
    S_EMIT1,
    S_EMIT2
  } state_t;

  typedef struct packed {
    logic                 serial_valid;
    logic [7:0]           serial_byte;
    logic [7:0]           cell_char;
    logic [7:0]           cell_attr;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tccw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tccw_outq.sv
// Two-entry result queue between the console controller and the output stream.
// Depends on tccw_pkg for the result record.
`default_nettype none

module tccw_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tccw_pkg::result_t push_res,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tccw_pkg::result_t     out_res
);

  tccw_pkg::result_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_res   = slot[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("result queue written while full");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

endmodule

`default_nettype wire

// File: rtl/tccw_ctrl.sv
// Console controller: cursor, attribute register and the sequencer that
// reads, writes, scrolls and clears the cell memory. Depends on tccw_pkg.
`default_nettype none

module tccw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tccw_pkg::kind_t   in_kind,
  input  wire logic [7:0]        in_code,
  input  wire logic [6:0]        in_column,
  input  wire logic [4:0]        in_row,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [15:0]            ram_wdata,
  output logic                   ram_re,
  output logic [AW-1:0]          ram_raddr,
  input  wire logic [15:0]       ram_rdata,
  output logic                   push,
  output tccw_pkg::result_t      push_res,
  input  wire logic              full
);

  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int NCOPY = CELLS - COLUMNS;

  tccw_pkg::state_t state, state_next;
  logic [CNTW-1:0]  cnt, cnt_next;
  logic [CW-1:0]    cur_col, cur_col_next;
  logic [RW-1:0]    cur_line, cur_line_next;
  logic [7:0]       attr;
  logic             clr_emit, clr_emit_next;

  tccw_pkg::kind_t  kind;
  logic [7:0]       code;
  logic             had_ret;
  logic             two;
  logic             rd_ok;

  logic             accept;
  logic             ret_now;
  logic             in_range;

  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
    cell_addr = r * AW'(COLUMNS) + c;
  endfunction

  assign in_ready = (state == tccw_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ret_now  = (cur_col >= CW'(COLUMNS)) || (in_code == tccw_pkg::CODE_NEWLINE);
  assign in_range = (int'(in_column) < COLUMNS) && (int'(in_row) < ROWS);

  always_ff @(posedge clk) begin
    if (accept) begin
      kind    <= in_kind;
      code    <= in_code;
      had_ret <= ret_now;
      two     <= ret_now && (in_code != tccw_pkg::CODE_NEWLINE);
      rd_ok   <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tccw_pkg::S_CLEAR;
      cnt      <= '0;
      cur_col  <= '0;
      cur_line <= '0;
      clr_emit <= 1'b0;
      attr     <= tccw_pkg::ATTR_RESET;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      cur_col  <= cur_col_next;
      cur_line <= cur_line_next;
      clr_emit <= clr_emit_next;
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cur_col_next  = cur_col;
    cur_line_next = cur_line;
    clr_emit_next = clr_emit;
    ram_we        = 1'b0;
    ram_waddr     = cnt[AW-1:0];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = cell_addr(AW'(in_row), AW'(in_column));
    push          = 1'b0;
    push_res      = '0;
    push_res.cursor_column = tccw_pkg::COL_OUT_W'(cur_col);
    push_res.cursor_row    = tccw_pkg::ROW_OUT_W'(cur_line);

    unique case (state)
      tccw_pkg::S_CLEAR: begin
        ram_we   = 1'b1;
        cnt_next = cnt + CNTW'(1);
        if (cnt == CNTW'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = clr_emit ? tccw_pkg::S_EMIT1 : tccw_pkg::S_IDLE;
        end
      end

      tccw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            tccw_pkg::KIND_PUT: begin
              state_next = tccw_pkg::S_PUT;
              if (ret_now) begin
                cur_col_next = '0;
                if (cur_line == RW'(ROWS - 1)) begin
                  cnt_next   = '0;
                  state_next = tccw_pkg::S_SCROLL;
                end else begin
                  cur_line_next = cur_line + RW'(1);
                end
              end
            end
            tccw_pkg::KIND_SET: begin
              cur_col_next  = (int'(in_column) > COLUMNS - 1) ? CW'(COLUMNS - 1)
                                                              : CW'(in_column);
              cur_line_next = (int'(in_row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(in_row);
              state_next    = tccw_pkg::S_EMIT1;
            end
            tccw_pkg::KIND_READ: begin
              ram_re     = in_range;
              state_next = tccw_pkg::S_EMIT1;
            end
            tccw_pkg::KIND_CLEAR: begin
              cur_col_next  = '0;
              cur_line_next = '0;
              cnt_next      = '0;
              clr_emit_next = 1'b1;
              state_next    = tccw_pkg::S_CLEAR;
            end
            default: ;
          endcase
        end
      end

      // Copy pipeline: the read issued at one step lands in the row above at the next.
      tccw_pkg::S_SCROLL: begin
        ram_raddr = AW'(cnt + CNTW'(COLUMNS));
        ram_re    = (cnt < CNTW'(NCOPY));
        ram_we    = (cnt != '0);
        ram_waddr = AW'(cnt - CNTW'(1));
        ram_wdata = ram_rdata;
        if (cnt == CNTW'(NCOPY)) begin
          state_next = tccw_pkg::S_BLANK;
        end else begin
          cnt_next = cnt + CNTW'(1);
        end
      end

      tccw_pkg::S_BLANK: begin
        ram_we = 1'b1;
        if (cnt == CNTW'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = tccw_pkg::S_PUT;
        end else begin
          cnt_next = cnt + CNTW'(1);
        end
      end

      tccw_pkg::S_PUT: begin
        if (code != tccw_pkg::CODE_NEWLINE) begin
          ram_we       = 1'b1;
          ram_waddr    = cell_addr(AW'(cur_line), AW'(cur_col));
          ram_wdata    = {attr, code};
          cur_col_next = cur_col + CW'(1);
        end
        state_next = tccw_pkg::S_EMIT1;
      end

      tccw_pkg::S_EMIT1: begin
        push_res.last = 1'b1;
        unique case (kind)
          tccw_pkg::KIND_PUT: begin
            push_res.serial_valid = 1'b1;
            push_res.serial_byte  = had_ret ? tccw_pkg::CODE_RETURN : code;
            push_res.last         = !two;
          end
          tccw_pkg::KIND_READ: begin
            push_res.cell_char = rd_ok ? ram_rdata[7:0]  : 8'd0;
            push_res.cell_attr = rd_ok ? ram_rdata[15:8] : 8'd0;
          end
          default: ;
        endcase
        if (!full) begin
          push          = 1'b1;
          clr_emit_next = 1'b0;
          state_next    = (kind == tccw_pkg::KIND_PUT && two) ? tccw_pkg::S_EMIT2
                                                               : tccw_pkg::S_IDLE;
        end
      end

      tccw_pkg::S_EMIT2: begin
        push_res.serial_valid = 1'b1;
        push_res.serial_byte  = code;
        push_res.last         = 1'b1;
        if (!full) begin
          push       = 1'b1;
          state_next = tccw_pkg::S_IDLE;
        end
      end

      default: state_next = tccw_pkg::S_IDLE;
    endcase
  end

  a_line_range : assert property (@(posedge clk) disable iff (rst)
    int'(cur_line) <= ROWS - 1)
    else $error("cursor row beyond the last row");

  a_col_range : assert property (@(posedge clk) disable iff (rst)
    int'(cur_col) <= COLUMNS)
    else $error("cursor column beyond the row end");

  a_put_in_row : assert property (@(posedge clk) disable iff (rst)
    state == tccw_pkg::S_PUT |-> int'(cur_col) < COLUMNS)
    else $error("character written past the row end");

  a_scroll_bottom : assert property (@(posedge clk) disable iff (rst)
    state == tccw_pkg::S_BLANK |-> cur_line == RW'(ROWS - 1))
    else $error("bottom row blanked while the cursor is not on it");

  a_emit_two_put : assert property (@(posedge clk) disable iff (rst)
    state == tccw_pkg::S_EMIT2 |-> kind == tccw_pkg::KIND_PUT && had_ret)
    else $error("second result for a request that has only one");

endmodule

`default_nettype wire

// File: rtl/text_console_cell_writer_unit.sv
// Top level of the text console cell writer.
// Depends on tccw_pkg, tccw_ram, tccw_ctrl and tccw_outq.
//
// Usage:
//   s_axis carries requests: tuser is the kind (put, set cursor, read cell,
//   clear screen), tdata the character, column and row. m_axis carries
//   results, one or two per request, tlast on the final one of a request.
//   cfg_wr_en/cfg_wr_data write the attribute byte used for every put; write
//   it only while no request is in flight.
//   A put other than a newline writes its cell before its results are queued;
//   clear screen first sweeps every cell to zero. A put that moves below the
//   last row scrolls first: the cell memory has one write port and moves one
//   cell per cycle. The next request is taken in the cycle after the last
//   result of the previous one is queued.
//   After reset the block sweeps the cell memory to zero with s_axis_tready
//   low; the attribute resets to 7.
//   A two-entry output queue decouples the receiver: when it stalls, results
//   wait in the queue and the sequencer holds once the queue is full.
`default_nettype none

module text_console_cell_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], column[14:8], row[19:15]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // serial_byte[7:0], cell_char[15:8], cell_attr[23:16], cursor_column[30:24],
  // cursor_row[35:31]
  output logic [39:0]      m_axis_tdata,
  output logic [0:0]       m_axis_tuser,  // serial_valid[0]
  output logic             m_axis_tlast
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;
  logic              push;
  logic              full;
  tccw_pkg::result_t push_res;
  tccw_pkg::result_t out_res;

  tccw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_kind     (tccw_pkg::kind_t'(s_axis_tuser)),
    .in_code     (s_axis_tdata[7:0]),
    .in_column   (s_axis_tdata[14:8]),
    .in_row      (s_axis_tdata[19:15]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .push        (push),
    .push_res    (push_res),
    .full        (full)
  );

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tccw_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .full      (full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.cursor_row, out_res.cursor_column,
                         out_res.cell_attr, out_res.cell_char, out_res.serial_byte};
  assign m_axis_tuser = out_res.serial_valid;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// File: test/tccw_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the text console cell writer: watches both stream channels and the
// attribute write port, keeps its own copy of the screen and cursor, and compares every result.
// Depends on tccw_pkg for the request kinds, the result record and the character codes.

module tccw_result_checker
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          outstanding
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [15:0] screen [CELLS];  // attribute in the high byte, character in the low byte
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic [7:0]  attribute;
  result_t     due_results [$];
  int          failures = 0;

  task automatic wipe_screen();
    for (int i = 0; i < CELLS; i++) begin
      screen[i] = '0;
    end
  endtask

  // Every result of one request carries the cursor as it stands after the request.
  function automatic result_t make_result(logic serial_valid, logic [7:0] serial_byte,
                                          logic [7:0] cell_char, logic [7:0] cell_attr);
    result_t r;
    r.serial_valid  = serial_valid;
    r.serial_byte   = serial_byte;
    r.cell_char     = cell_char;
    r.cell_attr     = cell_attr;
    r.cursor_column = cur_col;
    r.cursor_row    = cur_row;
    r.last          = 1'b0;
    return r;
  endfunction

  task automatic apply_request(kind_t kind, logic [7:0] code, logic [6:0] col, logic [4:0] row);
    result_t first;
    result_t second;
    int      count;
    bit      wrapped;
    int      addr;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
    count = 0;
    case (kind)
      KIND_PUT: begin
        wrapped = (cur_col >= COLUMNS) || (code == CODE_NEWLINE);
        if (wrapped) begin
          cur_row = cur_row + 5'd1;
          cur_col = '0;
        end
        if (cur_row > ROWS - 1) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = '0;
          end
          cur_row = ROWS - 1;
        end
        if (code != CODE_NEWLINE) begin
          addr = cur_row * COLUMNS + cur_col;
          if (addr < CELLS) begin
            screen[addr] = {attribute, code};
          end
          cur_col = cur_col + 7'd1;
        end
        if (wrapped) begin
          first = make_result(1'b1, CODE_RETURN, 8'd0, 8'd0);
          count = 1;
        end
        if (code != CODE_NEWLINE) begin
          if (count == 0) begin
            first = make_result(1'b1, code, 8'd0, 8'd0);
          end else begin
            second = make_result(1'b1, code, 8'd0, 8'd0);
          end
          count++;
        end
      end
      KIND_SET: begin
        cur_col = (col > COLUMNS - 1) ? 7'(COLUMNS - 1) : col;
        cur_row = (row > ROWS - 1) ? 5'(ROWS - 1) : row;
        first   = make_result(1'b0, 8'd0, 8'd0, 8'd0);
        count   = 1;
      end
      KIND_READ: begin
        rd_char = '0;
        rd_attr = '0;
        if (col < COLUMNS && row < ROWS) begin
          {rd_attr, rd_char} = screen[row * COLUMNS + col];
        end
        first = make_result(1'b0, 8'd0, rd_char, rd_attr);
        count = 1;
      end
      default: begin
        wipe_screen();
        cur_col = '0;
        cur_row = '0;
        first   = make_result(1'b0, 8'd0, 8'd0, 8'd0);
        count   = 1;
      end
    endcase
    if (count == 1) begin
      first.last = 1'b1;
      due_results.push_back(first);
    end else begin
      second.last = 1'b1;
      due_results.push_back(first);
      due_results.push_back(second);
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      failures++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      wipe_screen();
      cur_col   = '0;
      cur_row   = '0;
      attribute = ATTR_RESET;
      due_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.serial_valid  = m_axis_tuser[0];
        seen.serial_byte   = m_axis_tdata[7:0];
        seen.cell_char     = m_axis_tdata[15:8];
        seen.cell_attr     = m_axis_tdata[23:16];
        seen.cursor_column = m_axis_tdata[30:24];
        seen.cursor_row    = m_axis_tdata[35:31];
        seen.last          = m_axis_tlast;
        if (due_results.size() == 0) begin
          failures++;
          $error("unexpected result: serial_byte %0d cursor %0d,%0d",
                 seen.serial_byte, seen.cursor_column, seen.cursor_row);
        end else begin
          want = due_results.pop_front();
          check_field("serial_valid", want.serial_valid, seen.serial_valid);
          check_field("serial_byte", want.serial_byte, seen.serial_byte);
          check_field("cell_char", want.cell_char, seen.cell_char);
          check_field("cell_attr", want.cell_attr, seen.cell_attr);
          check_field("cursor_column", want.cursor_column, seen.cursor_column);
          check_field("cursor_row", want.cursor_row, seen.cursor_row);
          check_field("last", want.last, seen.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(kind_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[14:8],
                      s_axis_tdata[19:15]);
      end
      if (cfg_wr_en) begin
        attribute = cfg_wr_data;
      end
    end
    outstanding <= due_results.size();
    fail_count  <= failures;
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the text console cell writer testbench: clock, reset, request and result stimulus,
// attribute writes and the verdict. Depends on tccw_pkg, the block and tccw_result_checker.

module tb_top;
  import tccw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HEAVY_BUDGET = 110;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 244;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // char_code[7:0], column[14:8], row[19:15]
  logic [1:0]  s_axis_tuser;   // kind[1:0]
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // serial_byte, cell_char, cell_attr, cursor_column, cursor_row
  logic [0:0]  m_axis_tuser;   // serial_valid[0]
  logic        m_axis_tlast;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;

  // Rough cursor tracking, only so that scrolls and clears can be rationed.
  int trk_col = 0;
  int trk_row = 0;

  text_console_cell_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  tccw_result_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) result_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: bursts of readiness broken by stalls, with some long stall-free stretches.
  initial begin
    int run;
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      run   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      stall = idle_length();
      m_axis_tready <= 1'b1;
      repeat (run) @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  task automatic send_request(kind_t kind, logic [7:0] code, logic [6:0] col, logic [4:0] row);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, row, col, code};
    do @(posedge clk); while (!s_axis_tready);
    case (kind)
      KIND_PUT: begin
        if (trk_col >= COLUMNS || code == CODE_NEWLINE) begin
          trk_row++;
          trk_col = 0;
        end
        if (trk_row > ROWS - 1) trk_row = ROWS - 1;
        if (code != CODE_NEWLINE) trk_col++;
      end
      KIND_SET: begin
        trk_col = (col > COLUMNS - 1) ? COLUMNS - 1 : col;
        trk_row = (row > ROWS - 1) ? ROWS - 1 : row;
      end
      KIND_CLEAR: begin
        trk_col = 0;
        trk_row = 0;
      end
      default: ;
    endcase
  endtask

  task automatic pause_requests(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Hold requests back until every result is in and the block has settled.
  task automatic drain();
    pause_requests(1);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [7:0] attr_plan [PHASES];
    kind_t      kind;
    logic [7:0] code;
    logic [6:0] col;
    logic [4:0] row;
    int         pick;
    int         heavy_left;
    int         calm_left;
    bit         heavy;

    attr_plan     = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80, 8'h01, 8'h00, 8'h00};
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_PUT;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests, with the attribute still at its reset value.
    send_request(KIND_READ, 8'd0, 7'd0, 5'd0);
    send_request(KIND_PUT, 8'h41, 7'd0, 5'd0);
    send_request(KIND_PUT, 8'h00, 7'd0, 5'd0);
    send_request(KIND_PUT, 8'hFF, 7'd0, 5'd0);
    send_request(KIND_READ, 8'd0, 7'd0, 5'd0);
    send_request(KIND_READ, 8'd0, 7'd2, 5'd0);
    send_request(KIND_PUT, CODE_NEWLINE, 7'd0, 5'd0);
    // Fill the last column, then one more character wraps to the next row.
    send_request(KIND_SET, 8'd0, 7'(COLUMNS - 1), 5'd0);
    send_request(KIND_PUT, 8'h78, 7'd0, 5'd0);
    send_request(KIND_PUT, 8'h79, 7'd0, 5'd0);
    // Out-of-range cursor saturates to the bottom right corner.
    send_request(KIND_SET, 8'd0, 7'h7F, 5'h1F);
    send_request(KIND_PUT, 8'h7A, 7'd0, 5'd0);
    send_request(KIND_PUT, 8'h71, 7'd0, 5'd0);
    // A newline on the bottom row scrolls as well.
    send_request(KIND_SET, 8'd0, 7'd5, 5'(ROWS - 1));
    send_request(KIND_PUT, CODE_NEWLINE, 7'd0, 5'd0);
    send_request(KIND_READ, 8'd0, 7'(COLUMNS), 5'd0);
    send_request(KIND_READ, 8'd0, 7'd0, 5'(ROWS));
    send_request(KIND_READ, 8'd0, 7'h7F, 5'h1F);
    send_request(KIND_READ, 8'd0, 7'd0, 5'(ROWS - 2));
    send_request(KIND_READ, 8'd0, 7'(COLUMNS - 1), 5'(ROWS - 1));
    send_request(KIND_CLEAR, 8'd0, 7'd0, 5'd0);
    send_request(KIND_READ, 8'd0, 7'd0, 5'd0);

    heavy_left = HEAVY_BUDGET;
    calm_left  = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= (p >= 6) ? 8'($urandom) : attr_plan[p];
      @(negedge clk);
      cfg_wr_en   <= 1'b0;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        code = 8'($urandom_range(0, 255));
        if (pick < 62) begin
          kind = KIND_PUT;
          if ($urandom_range(0, 99) < 6) code = CODE_NEWLINE;
        end else if (pick < 72) begin
          kind = KIND_SET;
        end else if (pick < 98) begin
          kind = KIND_READ;
        end else begin
          kind = KIND_CLEAR;
        end

        pick = $urandom_range(0, 99);
        if (pick < 55) col = 7'($urandom_range(0, COLUMNS - 1));
        else if (pick < 85) col = 7'($urandom_range(COLUMNS - 8, COLUMNS - 1));
        else col = 7'($urandom_range(COLUMNS, 127));

        // Requests aim at the cursor row 45 percent of the time so that fresh writes get read back.
        pick = $urandom_range(0, 99);
        if (pick < 45) row = 5'(trk_row);
        else if (pick < 85) row = 5'($urandom_range(0, ROWS - 1));
        else if (pick < 92) row = 5'(ROWS - 1);
        else row = 5'($urandom_range(ROWS, 31));

        // Scrolls and clears each cost a full screen pass, so they are rationed.
        heavy = (kind == KIND_CLEAR) ||
                (kind == KIND_PUT && trk_row == ROWS - 1 &&
                 (trk_col >= COLUMNS || code == CODE_NEWLINE));
        if (heavy) begin
          if (heavy_left == 0) begin
            kind = KIND_SET;
            row  = 5'($urandom_range(0, ROWS - 2));
          end else begin
            heavy_left--;
          end
        end

        send_request(kind, code, col, row);

        if ($urandom_range(0, 149) == 0) begin
          drain();
        end else if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 99) == 0) begin
          calm_left = $urandom_range(30, 80);
        end else begin
          pause_requests(idle_length());
        end
      end
    end

    pause_requests(1);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
